[design/ptice_pkg.sv]
// ----------------------------------------------------------------------------
// ptice_pkg
// shared types, codes and constants of the temperature-interpolated
// polynomial coefficient evaluator
// ----------------------------------------------------------------------------
package ptice_pkg;

    localparam int NUM_TERMS_DEF = 8;

    // operation codes carried in tuser
    localparam logic [2:0] FN_LOAD   = 3'd0;
    localparam logic [2:0] FN_VALUE  = 3'd1;
    localparam logic [2:0] FN_DDT    = 3'd2;
    localparam logic [2:0] FN_DDB    = 3'd3;
    localparam logic [2:0] FN_D2DB2  = 3'd4;
    localparam logic [2:0] FN_DDTDB  = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SPAN_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT       = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_TEMP_LOW   = 2'd0;
    localparam logic [1:0] CFG_TEMP_HIGH  = 2'd1;
    localparam logic [1:0] CFG_TERMS_USED = 2'd2;

    localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

    // one coefficient of each set for the same power
    typedef struct packed {
        logic [31:0] c1;
        logic [31:0] c0;
    } t_cpair;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
        logic [31:0] rem;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SLOT,
        S_PREP,
        S_MUL_LO,
        S_MUL_HI,
        S_RND,
        S_ADD,
        S_DIFF,
        S_DCHK,
        S_DIV,
        S_FIN,
        S_COMB,
        S_OUT
    } t_state;

endpackage

[design/ptice_cell.sv]
// ----------------------------------------------------------------------------
// ptice_cell
// one ring cell: holds the lower and upper set coefficient of one power
// ----------------------------------------------------------------------------
module ptice_cell
    import ptice_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_shift,
    input  t_cpair      i_prev,
    input  logic        i_load,
    input  logic        i_load_set,
    input  logic [31:0] i_load_data,
    output t_cpair      o_pair
);

    t_cpair r_pair;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_pair <= i_prev;
        end else if (i_load) begin
            if (i_load_set) begin
                r_pair.c1 <= i_load_data;
            end else begin
                r_pair.c0 <= i_load_data;
            end
        end
    end

    assign o_pair = r_pair;

endmodule

[design/ptice_div.sv]
// ----------------------------------------------------------------------------
// ptice_div
// restoring divider, one quotient bit a cycle: {hi,lo} / den with hi < den
// ----------------------------------------------------------------------------
module ptice_div
    import ptice_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_hi,
    input  logic [63:0] i_lo,
    input  logic [31:0] i_den,
    output t_div_rsp    o_rsp
);

    logic        r_busy, r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem, r_den;
    logic [63:0] r_lq;
    logic [32:0] w_sh, w_sub;
    logic        w_ge;

    assign w_sh  = {r_rem, r_lq[63]};
    assign w_ge  = w_sh >= {1'b0, r_den};
    assign w_sub = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_hi;
            r_lq  <= i_lo;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[31:0] : w_sh[31:0];
            r_lq  <= {r_lq[62:0], w_ge};
        end
    end

    assign o_rsp = '{done: r_done, quot: r_lq, rem: r_rem};

endmodule

[design/poly_temp_interp_coeff_eval.sv]
// ----------------------------------------------------------------------------
// poly_temp_interp_coeff_eval
// evaluates two coefficient polynomials in flux density (horner form) and
// interpolates linearly in temperature, or gives a derivative of that
// ----------------------------------------------------------------------------
//
// channel   dir  fields (lowest bit first)
// s_axis    in   tdata: temperature 32, flux_density 32, coeff_set 1,
//                       term_index 3, coeff_value 32, zero 4; tuser: func 3
// m_axis    out  tdata: result_value 64; tuser: status 2
// i_cfg_*   in   index 0 temp_low, 1 temp_high, 2 terms_used (data[3:0])
//
// an evaluation walks the coefficient ring once, with every active term evaluated
// for two sets, five steps each on the shared 32x32 multiplier, then forms
// the span ratio on the 64-step divider; a zero span ends right after the
// ring walk. codes 6 and 7 give a zero result with ok status.
// reset is synchronous and active low; coefficients are not cleared.
// a result waiting in the output register does not block the next transfer.
// ----------------------------------------------------------------------------
module poly_temp_interp_coeff_eval
    import ptice_pkg::*;
#(
    parameter int NUM_TERMS = NUM_TERMS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration writes
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_wdata,
    // input items
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // temperature, flux_density, coeff_set,
                                        // term_index, coeff_value
    input  logic [2:0]   s_axis_tuser,  // func
    // results
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // result_value
    output logic [1:0]   m_axis_tuser   // status
);

    localparam int TW = (NUM_TERMS > 1) ? $clog2(NUM_TERMS) : 1;

    // saturate a rounded magnitude to signed 64 bits, {flag, value}
    function automatic logic [64:0] f_sat_sign(input logic [67:0] q, input logic neg);
        logic ps, ns;
        logic [63:0] v;
        ps = |q[67:63];
        ns = (|q[67:64]) | (q[63] & (|q[62:0]));
        if (neg) begin
            v = ns ? Q_MIN : (~q[63:0] + 64'd1);
            return {ns, v};
        end
        v = ps ? Q_MAX : q[63:0];
        return {ps, v};
    endfunction

    // saturating add or subtract of two signed 64 bit values, {flag, value}
    function automatic logic [64:0] f_sat_addsub(input logic [63:0] a, input logic [63:0] b,
                                                 input logic sub);
        logic [64:0] s;
        s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
        if (s[64] != s[63]) begin
            return {1'b1, s[64] ? Q_MIN : Q_MAX};
        end
        return {1'b0, s[63:0]};
    endfunction

    // input field views
    logic [31:0] w_in_temp, w_in_flux, w_in_cval;
    logic        w_in_set;
    logic [2:0]  w_in_idx;
    assign w_in_temp = s_axis_tdata[31:0];
    assign w_in_flux = s_axis_tdata[63:32];
    assign w_in_set  = s_axis_tdata[64];
    assign w_in_idx  = s_axis_tdata[67:65];
    assign w_in_cval = s_axis_tdata[99:68];

    // configuration
    logic [31:0] r_temp_low, r_temp_high;
    logic [3:0]  r_terms_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_low   <= 32'd0;
            r_temp_high  <= 32'd65536;
            r_terms_used <= 4'd1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_TEMP_LOW:   r_temp_low   <= i_cfg_wdata;
                CFG_TEMP_HIGH:  r_temp_high  <= i_cfg_wdata;
                CFG_TERMS_USED: r_terms_used <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // state
    t_state       r_state, n_state;
    logic [2:0]   r_func, n_func;
    logic [31:0]  r_b, n_b;
    logic [32:0]  r_dt, n_dt, r_span, n_span;
    logic [1:0]   r_k, n_k;
    logic [4:0]   r_n, n_n;
    logic [TW-1:0] r_slot, n_slot;
    logic         r_set, n_set, r_post, n_post, r_sat, n_sat, r_neg, n_neg;
    logic [63:0]  r_acc0, n_acc0, r_acc1, n_acc1;
    logic [63:0]  r_opa, n_opa;
    logic [31:0]  r_opb, n_opb;
    logic [48:0]  r_coef, n_coef;
    logic [63:0]  r_plo, n_plo;
    logic [95:0]  r_prod, n_prod;
    logic [63:0]  r_mv, n_mv, r_mq, n_mq, r_res, n_res;
    logic [1:0]   r_status, n_status;
    logic         r_ovalid, n_ovalid;
    logic [63:0]  r_odata, n_odata;
    logic [1:0]   r_ouser, n_ouser;

    // coefficient ring: cell i takes cell i-1, the last cell is the read head
    t_cpair w_cell [NUM_TERMS];
    logic   w_rot, w_load;

    assign w_load = s_axis_tvalid && s_axis_tready && (s_axis_tuser == FN_LOAD);

    for (genvar gi = 0; gi < NUM_TERMS; gi++) begin : g_ring
        ptice_cell u_cell (
            .i_clk       (i_clk),
            .i_shift     (w_rot),
            .i_prev      (w_cell[(gi + NUM_TERMS - 1) % NUM_TERMS]),
            .i_load      (w_load && ({1'b0, w_in_idx} == 4'(gi))),
            .i_load_set  (w_in_set),
            .i_load_data (w_in_cval),
            .o_pair      (w_cell[gi])
        );
    end

    // term under the head: after r rotations the head holds power N-1-r
    logic [TW-1:0] w_t;
    logic [4:0]    w_t5;
    logic          w_active, w_last, w_tderiv;
    logic [9:0]    w_tt;
    logic [7:0]    w_f;
    logic [31:0]   w_head_c, w_ud;
    logic [63:0]   w_acc_sel, w_mul;
    logic [95:0]   w_rnd;
    logic          w_ovf, w_out_free, w_span_zero, w_rup;
    logic [32:0]   w_m, w_mneg, w_spneg;
    logic [4:0]    w_n;

    assign w_t       = TW'(NUM_TERMS - 1) - r_slot;
    assign w_t5      = 5'(w_t);
    assign w_active  = (w_t5 < r_n) && (w_t5 >= {3'b0, r_k});
    assign w_last    = (r_slot == TW'(NUM_TERMS - 1));
    assign w_tt      = 10'(w_t5) * (10'(w_t5) - 10'd1);
    assign w_tderiv  = (r_func == FN_DDT) || (r_func == FN_DDTDB);
    assign w_head_c  = r_set ? w_cell[NUM_TERMS-1].c1 : w_cell[NUM_TERMS-1].c0;
    assign w_acc_sel = r_set ? r_acc1 : r_acc0;
    assign w_spneg   = ~r_span + 33'd1;
    assign w_ud      = r_span[32] ? w_spneg[31:0] : r_span[31:0];
    assign w_span_zero = (r_span == '0);
    assign w_m       = w_tderiv ? 33'd65536 : r_dt;
    assign w_mneg    = ~w_m + 33'd1;
    assign w_out_free = !r_ovalid || m_axis_tready;
    assign w_n = ({1'b0, r_terms_used} > 5'(NUM_TERMS)) ? 5'(NUM_TERMS)
                                                        : {1'b0, r_terms_used};

    always_comb begin
        case (r_k)
            2'd1:    w_f = 8'(w_t5);
            2'd2:    w_f = w_tt[7:0];
            default: w_f = 8'd1;
        endcase
    end

    // shared multiplier, low half then high half of the 64 bit operand
    assign w_mul = 64'((r_state == S_MUL_LO) ? r_opa[31:0] : r_opa[63:32]) * 64'(r_opb);
    assign w_rnd = r_prod + 96'h800_0000;
    assign w_ovf = r_prod[95:64] >= w_ud;

    t_div_rsp w_div;

    ptice_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == S_DCHK) && !w_ovf),
        .i_hi    (r_prod[95:64]),
        .i_lo    (r_prod[63:0]),
        .i_den   (w_ud),
        .o_rsp   (w_div)
    );

    // round half away: twice the remainder reaches the divisor
    assign w_rup = {w_div.rem, 1'b0} >= {1'b0, w_ud};

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_rot = ((r_state == S_SLOT) && !w_active) || ((r_state == S_ADD) && r_set);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == FN_LOAD) begin
                        n_state = S_IDLE;
                    end else if (s_axis_tuser >= FN_VALUE && s_axis_tuser <= FN_DDTDB) begin
                        n_state = S_SLOT;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_SLOT: begin
                if (w_active) begin
                    n_state = S_PREP;
                end else if (w_last) begin
                    n_state = S_DIFF;
                end
            end
            S_PREP:   n_state = S_MUL_LO;
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = r_post ? S_DCHK : S_RND;
            S_RND:    n_state = S_ADD;
            S_ADD: begin
                if (!r_set) begin
                    n_state = S_PREP;
                end else begin
                    n_state = w_last ? S_DIFF : S_SLOT;
                end
            end
            S_DIFF:   n_state = w_span_zero ? S_OUT : S_PREP;
            S_DCHK:   n_state = w_ovf ? S_COMB : S_DIV;
            S_DIV:    n_state = w_div.done ? S_FIN : S_DIV;
            S_FIN:    n_state = S_COMB;
            S_COMB:   n_state = S_OUT;
            S_OUT:    n_state = w_out_free ? S_IDLE : S_OUT;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        logic [64:0] v;
        n_func = r_func;   n_b = r_b;       n_dt = r_dt;     n_span = r_span;
        n_k = r_k;         n_n = r_n;       n_slot = r_slot; n_set = r_set;
        n_post = r_post;   n_sat = r_sat;   n_neg = r_neg;   n_acc0 = r_acc0;
        n_acc1 = r_acc1;   n_opa = r_opa;   n_opb = r_opb;   n_coef = r_coef;
        n_plo = r_plo;     n_prod = r_prod; n_mv = r_mv;     n_mq = r_mq;
        n_res = r_res;     n_status = r_status;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_odata = r_odata; n_ouser = r_ouser;
        v = '0;
        case (r_state)
            S_IDLE: begin
                n_func = s_axis_tuser;
                n_b    = w_in_flux;
                n_dt   = {w_in_temp[31], w_in_temp} - {r_temp_low[31], r_temp_low};
                n_span = {r_temp_high[31], r_temp_high} - {r_temp_low[31], r_temp_low};
                n_k    = (s_axis_tuser == FN_DDB || s_axis_tuser == FN_DDTDB) ? 2'd1 :
                         (s_axis_tuser == FN_D2DB2) ? 2'd2 : 2'd0;
                n_n    = w_n;
                n_slot = '0;
                n_set  = 1'b0;
                n_post = 1'b0;
                n_sat  = 1'b0;
                n_acc0 = '0;
                n_acc1 = '0;
                n_res  = '0;
                n_status = ST_OK;
            end
            S_SLOT: begin
                if (!w_active) begin
                    n_slot = w_last ? '0 : r_slot + TW'(1);
                end
            end
            S_PREP: begin
                if (r_post) begin
                    n_opa = r_mv[63] ? (~r_mv + 64'd1) : r_mv;
                    n_opb = w_m[32] ? w_mneg[31:0] : w_m[31:0];
                    n_neg = r_mv[63] ^ w_m[32] ^ r_span[32];
                end else begin
                    n_opa  = w_acc_sel[63] ? (~w_acc_sel + 64'd1) : w_acc_sel;
                    n_opb  = r_b[31] ? (~r_b + 32'd1) : r_b;
                    n_neg  = w_acc_sel[63] ^ r_b[31];
                    n_coef = $signed({w_head_c, 8'b0}) * $signed({1'b0, w_f});
                end
            end
            S_MUL_LO: n_plo = w_mul;
            S_MUL_HI: n_prod = {w_mul, 32'b0} + {32'b0, r_plo};
            S_RND: begin
                v     = f_sat_sign(w_rnd[95:28], r_neg);
                n_mv  = v[63:0];
                n_sat = r_sat | v[64];
            end
            S_ADD: begin
                v     = f_sat_addsub(r_mv, {{15{r_coef[48]}}, r_coef}, 1'b0);
                n_sat = r_sat | v[64];
                if (r_set) begin
                    n_acc1 = v[63:0];
                    n_set  = 1'b0;
                    n_slot = w_last ? '0 : r_slot + TW'(1);
                end else begin
                    n_acc0 = v[63:0];
                    n_set  = 1'b1;
                end
            end
            S_DIFF: begin
                if (w_span_zero) begin
                    n_res    = w_tderiv ? '0 : r_acc0;
                    n_status = ST_SPAN_ZERO;
                end else begin
                    v      = f_sat_addsub(r_acc1, r_acc0, 1'b1);
                    n_mv   = v[63:0];
                    n_sat  = r_sat | v[64];
                    n_post = 1'b1;
                end
            end
            S_DCHK: begin
                if (w_ovf) begin
                    n_sat = 1'b1;
                    n_mq  = r_neg ? Q_MIN : Q_MAX;
                end
            end
            S_FIN: begin
                v     = f_sat_sign(68'({1'b0, w_div.quot} + 65'(w_rup)), r_neg);
                n_mq  = v[63:0];
                n_sat = r_sat | v[64];
            end
            S_COMB: begin
                if (w_tderiv) begin
                    n_res    = r_mq;
                    n_status = r_sat ? ST_SAT : ST_OK;
                end else begin
                    v        = f_sat_addsub(r_acc0, r_mq, 1'b0);
                    n_res    = v[63:0];
                    n_status = (r_sat || v[64]) ? ST_SAT : ST_OK;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_res;
                    n_ouser  = r_status;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_slot   <= '0;
            r_set    <= 1'b0;
            r_post   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_slot   <= n_slot;
            r_set    <= n_set;
            r_post   <= n_post;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= n_func;   r_b <= n_b;       r_dt <= n_dt;       r_span <= n_span;
        r_k <= n_k;         r_n <= n_n;       r_sat <= n_sat;     r_neg <= n_neg;
        r_acc0 <= n_acc0;   r_acc1 <= n_acc1; r_opa <= n_opa;     r_opb <= n_opb;
        r_coef <= n_coef;   r_plo <= n_plo;   r_prod <= n_prod;   r_mv <= n_mv;
        r_mq <= n_mq;       r_res <= n_res;   r_status <= n_status;
        r_odata <= n_odata; r_ouser <= n_ouser;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    // ring is back home whenever a new item may come in
    ap_ring_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_slot == '0 && !r_set))
        else $error("coefficient ring not at home position while idle");

    ap_mul_halves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_LO) |=> (r_state == S_MUL_HI))
        else $error("multiplier high half skipped");

    ap_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == S_OUT))
        else $error("output register loaded outside result state");

    ap_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> $past(w_div.done))
        else $error("quotient used before divider finished");

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// checks poly_temp_interp_coeff_eval: a directed table (part of it with typed
// answers) followed by random loads and evaluations over several register
// settings, each untyped result compared against a behavioral interpolator
// ----------------------------------------------------------------------------
module testbench;
    import ptice_pkg::*;

    // codes that the package leaves unnamed
    localparam logic [2:0] FN_ZERO   = 3'd6;
    localparam logic [2:0] FN_UNUSED = 3'd7;
    localparam int STALL_LIMIT = 5000;  // cycles without any transfer
    localparam int DRAIN_CYCLES = 200;  // longer than the longest evaluation

    typedef struct {
        logic [63:0] value;
        logic [1:0]  status;
    } t_interp_result;

    typedef struct {
        logic [2:0]  fn;
        logic [31:0] temp;
        logic [31:0] flux;
        logic        set;
        logic [2:0]  idx;
        logic [31:0] coeff;
        bit          typed;   // expected result written in the row
        logic [63:0] value;
        logic [1:0]  status;
    } t_stim_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wr_en = 1'b0;
    logic [1:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;  // temperature, flux_density, coeff_set,
                                      // term_index, coeff_value, zero fill
    logic [2:0]   s_axis_tuser = '0;  // func
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;       // result_value
    logic [1:0]   m_axis_tuser;       // status

    poly_temp_interp_coeff_eval u_top (.*);

    always #5 i_clk = ~i_clk;

    // local copy of the block state
    logic signed [31:0] mdl_temp_low = 32'sd0;
    logic signed [31:0] mdl_temp_high = 32'sd65536;
    logic [3:0]         mdl_terms = 4'd1;
    logic signed [31:0] mdl_coeffs [16];

    t_interp_result expected_q [$];
    t_stim_row      dir_rows [$];
    int  err_count = 0;
    bit  quiet = 1'b0;      // no idling on either side while set
    int  watchdog = 0;

    // ---------------------------------------------------------------- predictor
    function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   inout bit sat);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            sat = 1'b1;
            return s[64] ? Q_MIN : Q_MAX;
        end
        return s[63:0];
    endfunction

    // round(a*b/d) to nearest, ties away from zero, saturating
    function automatic logic signed [63:0] scaled_ratio(input logic signed [63:0] a,
                                                        input logic signed [63:0] b,
                                                        input logic signed [63:0] d,
                                                        inout bit sat);
        bit          neg;
        logic [63:0] ua, ub, ud, q;
        logic [127:0] prod, rem;
        logic [64:0] q_rnd;
        neg = ((a < 0) != (b < 0)) != (d < 0);
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        ud = d < 0 ? -d : d;
        if (ud == 0)
            return 0;
        prod = {64'd0, ua} * {64'd0, ub};
        if (prod[127:64] >= ud) begin
            sat = 1'b1;
            return neg ? Q_MIN : Q_MAX;
        end
        q = 64'(prod / {64'd0, ud});
        rem = prod % {64'd0, ud};
        q_rnd = {1'b0, q};
        if (rem[63:0] >= ud - rem[63:0])
            q_rnd = q_rnd + 1;
        if (q_rnd[64]) begin
            sat = 1'b1;
            return neg ? Q_MIN : Q_MAX;
        end
        if (neg) begin
            if (q_rnd[63:0] > Q_MIN) begin
                sat = 1'b1;
                return Q_MIN;
            end
            return -q_rnd[63:0];
        end
        if (q_rnd[63]) begin
            sat = 1'b1;
            return Q_MAX;
        end
        return q_rnd[63:0];
    endfunction

    // horner over one coefficient set, derivative order k in flux density
    function automatic logic signed [63:0] flux_poly(input int set, input int k,
                                                     input logic signed [31:0] flux,
                                                     inout bit sat);
        logic signed [63:0] acc, term;
        int n, t, f;
        acc = 0;
        n = mdl_terms > 8 ? 8 : mdl_terms;
        for (int j = n; j > k; j--) begin
            t = j - 1;
            f = (k == 1) ? t : (k == 2) ? t * (t - 1) : 1;
            acc = scaled_ratio(acc, 64'(flux), 64'sh1000_0000, sat);
            term = 64'(mdl_coeffs[set * 8 + t]) * 256 * f;
            acc = sat_sum(acc, term, sat);
        end
        return acc;
    endfunction

    function automatic t_interp_result interpolate(input logic [2:0] fn,
                                                   input logic signed [31:0] temp,
                                                   input logic signed [31:0] flux);
        t_interp_result r;
        logic signed [63:0] span, dt, q0, q1, diff;
        bit sat;
        int k;
        sat = 1'b0;
        r.value = '0;
        r.status = ST_OK;
        if (fn == FN_ZERO || fn == FN_UNUSED)
            return r;
        span = 64'(mdl_temp_high) - 64'(mdl_temp_low);
        dt = 64'(temp) - 64'(mdl_temp_low);
        k = (fn == FN_DDB || fn == FN_DDTDB) ? 1 : (fn == FN_D2DB2) ? 2 : 0;
        q0 = flux_poly(0, k, flux, sat);
        q1 = flux_poly(1, k, flux, sat);
        if (span == 0) begin
            r.value = (fn == FN_DDT || fn == FN_DDTDB) ? 64'd0 : q0;
            r.status = ST_SPAN_ZERO;
        end else begin
            // the lowest value cannot be negated, so subtract it directly
            if (q0 == Q_MIN) begin
                if (q1 >= 0) begin
                    sat = 1'b1;
                    diff = Q_MAX;
                end else begin
                    diff = q1 - q0;
                end
            end else begin
                diff = sat_sum(q1, -q0, sat);
            end
            if (fn == FN_DDT || fn == FN_DDTDB)
                r.value = scaled_ratio(diff, 64'sd65536, span, sat);
            else
                r.value = sat_sum(q0, scaled_ratio(diff, dt, span, sat), sat);
            r.status = sat ? ST_SAT : ST_OK;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- drivers
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_TEMP_LOW:   mdl_temp_low = data;
            CFG_TEMP_HIGH:  mdl_temp_high = data;
            CFG_TERMS_USED: mdl_terms = data[3:0];
            default: ;
        endcase
    endtask

    // block idle: input released, all results back, then room for a trailing load
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_phase(input logic [31:0] lo, input logic [31:0] hi,
                             input logic [3:0] terms);
        wait_idle();
        cfg_write(CFG_TEMP_LOW, lo);
        cfg_write(CFG_TEMP_HIGH, hi);
        cfg_write(CFG_TERMS_USED, {28'd0, terms});
    endtask

    task automatic send_row(input t_stim_row row);
        t_interp_result r;
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= row.fn;
        s_axis_tdata <= {4'd0, row.coeff, row.idx, row.set, row.flux, row.temp};
        do @(posedge i_clk); while (!s_axis_tready);
        // transfer accepted at this edge
        if (row.fn == FN_LOAD) begin
            mdl_coeffs[row.set * 8 + row.idx] = row.coeff;
        end else begin
            if (row.typed) begin
                r.value = row.value;
                r.status = row.status;
            end else begin
                r = interpolate(row.fn, row.temp, row.flux);
            end
            expected_q.push_back(r);
        end
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_stim_row mk_row(input logic [2:0] fn, input logic [31:0] temp,
                                         input logic [31:0] flux, input logic set,
                                         input logic [2:0] idx, input logic [31:0] coeff,
                                         input bit typed, input logic [63:0] value,
                                         input logic [1:0] status);
        t_stim_row r;
        r.fn = fn; r.temp = temp; r.flux = flux; r.set = set; r.idx = idx;
        r.coeff = coeff; r.typed = typed; r.value = value; r.status = status;
        return r;
    endfunction

    // random item: loads and evaluations around the configured span
    function automatic t_stim_row rand_row();
        t_stim_row r;
        logic signed [31:0] span;
        r = mk_row(3'($urandom_range(1, 7)), '0, '0, 1'($urandom_range(0, 1)),
                   3'($urandom_range(0, 7)), '0, 1'b0, '0, ST_OK);
        if ($urandom_range(0, 4) == 0) begin
            r.fn = FN_LOAD;
            // mostly moderate coefficients so deep polynomials stay in range
            r.coeff = ($urandom_range(0, 3) == 0) ? $urandom()
                                                   : 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
        end
        span = mdl_temp_high - mdl_temp_low;
        case ($urandom_range(0, 5))
            0: r.temp = $urandom();
            1: r.temp = mdl_temp_low;
            2: r.temp = mdl_temp_high;
            default: r.temp = mdl_temp_low + 32'($signed($urandom_range(0, 65536 * 4))
                                                  - 65536 * 2);
        endcase
        if (span != 0 && $urandom_range(0, 1) == 0)
            r.temp = mdl_temp_low + 32'(64'(span) * $urandom_range(0, 1000) / 1000);
        r.flux = ($urandom_range(0, 4) == 0) ? $urandom()
                                              : 32'($signed($urandom_range(0, 32'h3000_0000))
                                                    - 32'sh1800_0000);
        // noise in the fields that the operation does not use
        if (r.fn != FN_LOAD)
            r.coeff = $urandom();
        return r;
    endfunction

    // ---------------------------------------------------------------- result side
    int stall_left = 0;
    int stall_draw;

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            stall_draw = quiet ? 0 : $urandom_range(0, 9);
            stall_left <= stall_draw;
            m_axis_tready <= (stall_draw == 0);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_interp_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result value=%h status=%0d",
                             m_axis_tdata, m_axis_tuser);
            end else begin
                exp_r = expected_q.pop_front();
                if (m_axis_tdata !== exp_r.value || m_axis_tuser !== exp_r.status) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                                 exp_r.value, exp_r.status, m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    // end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || i_cfg_wr_en)
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    initial begin
        logic [31:0] lo, hi;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the whole table first so no entry is ever read unwritten
        quiet = 1'b1;
        for (int e = 0; e < 16; e++)
            send_row(mk_row(FN_LOAD, $urandom(), $urandom(), 1'(e / 8), 3'(e % 8),
                            32'($signed($urandom_range(0, 1 << 26)) - (1 << 25)),
                            1'b0, '0, ST_OK));
        quiet = 1'b0;

        // reset registers: span one degree from zero, a single constant term
        // set 0 holds 1.0 and set 1 holds 3.0 in q8.24
        dir_rows.push_back(mk_row(FN_LOAD, 0, 0, 1'b0, 3'd0, 32'h0100_0000, 0, 0, ST_OK));
        dir_rows.push_back(mk_row(FN_LOAD, 0, 0, 1'b1, 3'd0, 32'h0300_0000, 0, 0, ST_OK));
        dir_rows.push_back(mk_row(FN_VALUE, 32'd0, 32'h8000_0000, 0, 0, 0,
                                  1, 64'h1_0000_0000, ST_OK));
        dir_rows.push_back(mk_row(FN_VALUE, 32'd65536, 32'h7FFF_FFFF, 0, 0, 0,
                                  1, 64'h3_0000_0000, ST_OK));
        dir_rows.push_back(mk_row(FN_VALUE, 32'd32768, 32'd0, 0, 0, 0,
                                  1, 64'h2_0000_0000, ST_OK));
        dir_rows.push_back(mk_row(FN_DDT, 32'd0, 32'd0, 0, 0, 0,
                                  1, 64'h2_0000_0000, ST_OK));
        // with a single term every flux derivative is empty
        dir_rows.push_back(mk_row(FN_DDB, 32'd0, 32'hFFFF_FFFF, 0, 0, 0, 1, 0, ST_OK));
        dir_rows.push_back(mk_row(FN_D2DB2, 32'd0, 32'd0, 0, 0, 0, 1, 0, ST_OK));
        dir_rows.push_back(mk_row(FN_DDTDB, 32'd0, 32'd0, 0, 0, 0, 1, 0, ST_OK));
        dir_rows.push_back(mk_row(FN_ZERO, $urandom(), $urandom(), 1, 7, $urandom(),
                                  1, 0, ST_OK));
        dir_rows.push_back(mk_row(FN_UNUSED, $urandom(), $urandom(), 1, 7, $urandom(),
                                  1, 0, ST_OK));
        // temperature extremes drive the interpolation far outside the span
        dir_rows.push_back(mk_row(FN_VALUE, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, ST_OK));
        dir_rows.push_back(mk_row(FN_VALUE, 32'h8000_0000, 0, 0, 0, 0, 0, 0, ST_OK));
        // coefficient extremes
        dir_rows.push_back(mk_row(FN_LOAD, 0, 0, 1'b0, 3'd0, 32'h7FFF_FFFF, 0, 0, ST_OK));
        dir_rows.push_back(mk_row(FN_LOAD, 0, 0, 1'b1, 3'd0, 32'h8000_0000, 0, 0, ST_OK));
        dir_rows.push_back(mk_row(FN_VALUE, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, ST_OK));
        dir_rows.push_back(mk_row(FN_DDT, 32'd0, 0, 0, 0, 0, 0, 0, ST_OK));
        foreach (dir_rows[r])
            send_row(dir_rows[r]);

        // all terms, wide flux: derivatives in flux density become non-trivial
        set_phase(32'd0, 32'd65536, 4'd8);
        for (int n = 0; n < 6; n++)
            send_row(mk_row(FN_VALUE + 3'(n % 5), 32'd16384,
                            n[0] ? 32'h7FFF_FFFF : 32'h8000_0000, 0, 0, 0, 0, 0, ST_OK));

        // zero span: lower set, no temperature derivative
        set_phase(32'h0014_0000, 32'h0014_0000, 4'd3);
        for (int f = 1; f <= 5; f++)
            send_row(mk_row(3'(f), 32'h0020_0000, 32'h1000_0000, 0, 0, 0, 0, 0, ST_OK));

        // random phases, register extremes first
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
                1: begin lo = 32'h7FFF_FFFF; hi = 32'h8000_0000; end
                2: begin lo = 32'h0005_0000; hi = 32'h0005_0000; end
                default: begin
                    lo = 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
                    hi = lo + $urandom_range(1, 150 << 16);
                end
            endcase
            set_phase(lo, hi, (ph < 3) ? 4'd8 : 4'($urandom_range(1, 8)));
            quiet = (ph == 4);
            for (int n = 0; n < 50; n++)
                send_row(rand_row());
            quiet = 1'b0;
        end
        s_axis_tvalid <= 1'b0;

        wait_idle();
        if (err_count == 0 && expected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[poly_temp_interp_coeff_eval.f]
design/ptice_pkg.sv
design/ptice_cell.sv
design/ptice_div.sv
design/poly_temp_interp_coeff_eval.sv
tb/testbench.sv
